// ===== rtl/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned OnesW     = 4;
  localparam int unsigned RemW      = 3;
  localparam int unsigned CpW       = 42;
  localparam int unsigned CntW      = 4;
  localparam int unsigned Shift6    = 6;
  localparam int unsigned TopBit    = 7;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 48;
  localparam int unsigned FifoDepth = 2;

  localparam logic [Shift6-1:0] Low6Mask = 6'h3f;

  localparam logic StatusComplete  = 1'b0;
  localparam logic StatusTruncated = 1'b1;

  // One byte after classification by the front end.
  typedef struct packed {
    logic [OnesW-1:0]  ones;       // count of leading one bits of the byte
    logic [ByteW-1:0]  lead_bits;  // bits below the leading ones
    logic [Shift6-1:0] low6;       // payload bits of a following byte
    logic              last;       // final byte of the buffer
  } cls_item_t;

  function automatic logic [OnesW-1:0] lead_ones(logic [ByteW-1:0] b);
    logic [OnesW-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = TopBit; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + OnesW'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8d_front.sv =====
`default_nettype none

// Takes bytes from the stream and classifies each into a queue entry.
module u8d_front (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [u8d_pkg::ByteW-1:0]     s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,
  input  wire logic                          fifo_full_i,
  output logic                               push_o,
  output u8d_pkg::cls_item_t                 push_item_o
);

  logic [u8d_pkg::OnesW-1:0] ones;

  always_comb begin
    ones = u8d_pkg::lead_ones(s_axis_tdata_i);
  end

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;

  always_comb begin
    push_item_o.ones      = ones;
    push_item_o.lead_bits = s_axis_tdata_i & (u8d_pkg::ByteW'(8'hFF) >> ones);
    push_item_o.low6      = s_axis_tdata_i[u8d_pkg::Shift6-1:0] & u8d_pkg::Low6Mask;
    push_item_o.last      = s_axis_tlast_i;
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_fifo.sv =====
`default_nettype none

// Small register queue between the front end and the decoder.
module u8d_fifo #(
  parameter int unsigned Depth = u8d_pkg::FifoDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire u8d_pkg::cls_item_t push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    not_empty_o,
  output u8d_pkg::cls_item_t      pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_pkg::cls_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8d_back.sv =====
`default_nettype none

// Sequence decoder: holds the open sequence and the output register.
module u8d_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        not_empty_i,
  input  wire u8d_pkg::cls_item_t          item_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [u8d_pkg::CpW-1:0]          out_cp_o,
  output logic [u8d_pkg::CntW-1:0]         out_cnt_o,
  output logic                             out_status_o
);

  logic [u8d_pkg::RemW-1:0]  rem_q, rem_d;
  logic [u8d_pkg::CpW-1:0]   acc_q, acc_d;
  logic [u8d_pkg::CntW-1:0]  len_q, len_d;
  logic                      out_valid_q, out_valid_d;
  logic [u8d_pkg::CpW-1:0]   out_cp_q, out_cp_d;
  logic [u8d_pkg::CntW-1:0]  out_cnt_q, out_cnt_d;
  logic                      out_st_q, out_st_d;
  logic [u8d_pkg::CpW-1:0]   acc_shift;
  logic [u8d_pkg::RemW-1:0]  rem_dec;

  assign pop_o = not_empty_i && (!out_valid_q || m_axis_tready_i);

  assign acc_shift = {acc_q[u8d_pkg::CpW-u8d_pkg::Shift6-1:0], item_i.low6};
  assign rem_dec   = rem_q - u8d_pkg::RemW'(1);

  always_comb begin
    rem_d       = rem_q;
    acc_d       = acc_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_cp_d    = out_cp_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    if (pop_o) begin
      if (rem_q == '0) begin
        if (item_i.ones <= u8d_pkg::OnesW'(1)) begin
          // Plain byte or lone following byte: a character on its own.
          out_valid_d = 1'b1;
          out_cp_d    = u8d_pkg::CpW'(item_i.lead_bits);
          out_cnt_d   = u8d_pkg::CntW'(1);
          out_st_d    = u8d_pkg::StatusComplete;
        end else if (item_i.last) begin
          out_valid_d = 1'b1;
          out_cp_d    = '0;
          out_cnt_d   = '0;
          out_st_d    = u8d_pkg::StatusTruncated;
        end else begin
          acc_d = u8d_pkg::CpW'(item_i.lead_bits);
          len_d = item_i.ones;
          rem_d = u8d_pkg::RemW'(item_i.ones - u8d_pkg::OnesW'(1));
        end
      end else if (rem_dec == '0) begin
        out_valid_d = 1'b1;
        out_cp_d    = acc_shift;
        out_cnt_d   = len_q;
        out_st_d    = u8d_pkg::StatusComplete;
        rem_d       = '0;
        acc_d       = '0;
        len_d       = '0;
      end else if (item_i.last) begin
        out_valid_d = 1'b1;
        out_cp_d    = '0;
        out_cnt_d   = '0;
        out_st_d    = u8d_pkg::StatusTruncated;
        rem_d       = '0;
        acc_d       = '0;
        len_d       = '0;
      end else begin
        acc_d = acc_shift;
        rem_d = rem_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      acc_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cp_q  <= out_cp_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign out_cp_o        = out_cp_q;
  assign out_cnt_o       = out_cnt_q;
  assign out_status_o    = out_st_q;

endmodule

`default_nettype wire

// ===== rtl/utf8_code_point_decode_top.sv =====
// A byte that completes or cuts off a sequence is written into the queue at
// the edge that accepts it, and its item shows on the output once the decoder
// has popped it into its output register; a stalled output can hold it back.
// Throughput: one byte per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) empties the queue, closes any open
// sequence and drops a waiting output item.
`default_nettype none

module utf8_code_point_decode_top #(
  // Number of classified bytes the queue can hold between the two halves.
  parameter int unsigned FifoDepth = u8d_pkg::FifoDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Byte stream in.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [u8d_pkg::TdataInW-1:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                           s_axis_tlast_i,  // last_byte
  // Code points out.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [u8d_pkg::TdataOutW-1:0]       m_axis_tdata_o,  // [41:0] code_point,
                                                               // [45:42] byte_count,
                                                               // [47:46] zero
  output logic                                m_axis_tuser_o   // status
);

  // The front end only classifies each byte; it needs no knowledge of the
  // open sequence, so it can fill the queue while the decoder is stalled.
  logic               fifo_full;
  logic               push;
  u8d_pkg::cls_item_t push_item;

  // The decoder drains the queue whenever its output register is free or is
  // being emptied in the same cycle.
  logic               fifo_not_empty;
  logic               pop;
  u8d_pkg::cls_item_t pop_item;

  logic [u8d_pkg::CpW-1:0]  out_cp;
  logic [u8d_pkg::CntW-1:0] out_cnt;

  u8d_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i[u8d_pkg::ByteW-1:0]),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  u8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .not_empty_o (fifo_not_empty),
    .pop_item_o  (pop_item)
  );

  u8d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .not_empty_i     (fifo_not_empty),
    .item_i          (pop_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .out_cp_o        (out_cp),
    .out_cnt_o       (out_cnt),
    .out_status_o    (m_axis_tuser_o)
  );

  // Code point in the low bits, byte count above it, padded to whole bytes.
  assign m_axis_tdata_o = u8d_pkg::TdataOutW'({out_cnt, out_cp});

endmodule

`default_nettype wire

// ===== rtl/u8d_checker.sv =====
`default_nettype none

module u8d_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [u8d_pkg::TdataInW-1:0]  s_axis_tdata_i,
  input wire logic                          s_axis_tlast_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [u8d_pkg::TdataOutW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tuser_o
);

  // No item is offered while reset is held.
  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A cut-off sequence carries neither value nor count.
  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("truncated item with non-zero data");

  // A complete character spans one to eight bytes.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[45:42] != 4'd0) && (m_axis_tdata_o[45:42] <= 4'd8))
    else $error("byte count out of range");

  // A byte offered on the input holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && !s_axis_tready_o) |=>
      (s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tlast_i)))
    else $error("input item changed while waiting");

  // A stalled item holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("output item changed while stalled");

endmodule

bind utf8_code_point_decode_top u8d_checker u_u8d_checker (.*);

`default_nettype wire
